/* rtl/hll_pkg.sv */
// Shared types and constants for the HyperLogLog sketch block.
// Used by the divider and the top level; depends on nothing.
`default_nettype none

package hll_pkg;

  // Widths of the command, result and configuration fields and of internal values.
  localparam int HASH_W  = 64;
  localparam int HALF_W  = 32;
  localparam int BC_W    = 11;
  localparam int CW_W    = 4;
  localparam int ALPHA_W = 16;
  localparam int EST_W   = 48;
  localparam int EMPTY_W = 11;
  localparam int SUM_W   = 42;
  localparam int CTR_W   = 8;
  localparam int RANK_W  = 6;
  localparam int MM_W    = 2 * BC_W;
  localparam int PROD_W  = ALPHA_W + MM_W;

  // Q.32 fraction of the harmonic sum.
  localparam int FRAC_BITS = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 2'd2;

  localparam logic [BC_W-1:0]    BUCKET_COUNT_RST  = 11'd1024;
  localparam logic [CW_W-1:0]    COUNTER_WIDTH_RST = 4'd6;
  localparam logic [ALPHA_W-1:0] ALPHA_RST         = 16'd47220;

  // Command codes.
  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_ESTIMATE = 1'b1;

  // Saturated estimate.
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

  // Request to and response from the shared divider.
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] quot;
    logic [SUM_W-1:0]  rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/hyperloglog_cardinality_sketch_top.sv */
// HyperLogLog sketch top level: sequencer, rank table and shared divider.
// Depends on hll_pkg, hll_divider and hll_rank_mem.
//
// After reset the block runs a clearing pass over the rank table with busy
// high; configuration writes are taken meanwhile. A command word is taken
// when start is high and busy is low. For an insert the bucket index comes
// from the shared 64-step restoring divider (hash modulo bucket count),
// followed by a read and a write of the table entry. An estimate walks the m
// buckets in use, one table read per cycle, then forms alpha*m*m in the
// states S_EST_MUL1 and S_EST_MUL2 and divides by the harmonic sum on the
// same divider, or skips the divide when the harmonic sum is zero. The result
// word appears for one cycle with out_valid and cannot be held off by the
// receiver; an insert gives no result word.
`default_nettype none

module hyperloglog_cardinality_sketch_top #(
  parameter int MAX_BUCKETS = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Command channel.
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   in_op,
  input  wire  [hll_pkg::HASH_W-1:0]            in_hash,
  // Result channel.
  output logic                                  out_valid,
  output logic [hll_pkg::EST_W-1:0]             out_raw_estimate,
  output logic [hll_pkg::EMPTY_W-1:0]           out_empty_buckets,
  output logic [hll_pkg::SUM_W-1:0]             out_harmonic_sum,
  output logic                                  out_saturated,
  // Configuration port.
  input  wire                                   cfg_we,
  input  wire  [hll_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [hll_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int IdxW   = $clog2(MAX_BUCKETS);
  localparam int CntW   = IdxW + 1;
  localparam int BcW    = hll_pkg::BC_W;
  localparam int CwW    = hll_pkg::CW_W;
  localparam int AlphaW = hll_pkg::ALPHA_W;
  localparam int CtrW   = hll_pkg::CTR_W;
  localparam int RankW  = hll_pkg::RANK_W;
  localparam int SumW   = hll_pkg::SUM_W;
  localparam int HashW  = hll_pkg::HASH_W;
  localparam int HalfW  = hll_pkg::HALF_W;
  localparam int EstW   = hll_pkg::EST_W;
  localparam int EmptyW = hll_pkg::EMPTY_W;
  localparam int MmW    = hll_pkg::MM_W;
  localparam int ProdW  = hll_pkg::PROD_W;
  localparam int Frac   = hll_pkg::FRAC_BITS;
  localparam int PadW   = HashW - ProdW - AlphaW;

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_INS_DIV   = 11'b000_0000_0100,
    S_INS_READ  = 11'b000_0000_1000,
    S_INS_WRITE = 11'b000_0001_0000,
    S_EST_WALK  = 11'b000_0010_0000,
    S_EST_LAST  = 11'b000_0100_0000,
    S_EST_MUL1  = 11'b000_1000_0000,
    S_EST_MUL2  = 11'b001_0000_0000,
    S_EST_DIV   = 11'b010_0000_0000,
    S_EST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [BcW-1:0]    bucket_count_r;
  logic [CwW-1:0]    counter_width_r;
  logic [AlphaW-1:0] alpha_r;

  // Per-command working registers.
  logic [CntW-1:0]   m_r;
  logic [CtrW-1:0]   mask_r;
  logic [IdxW-1:0]   clr_cnt_r;
  logic [IdxW-1:0]   walk_idx_r;
  logic [IdxW-1:0]   bucket_r;
  logic [HalfW-1:0]  hi_r;
  logic [RankW-1:0]  tz_r;
  logic              tz_found_r;
  logic              acc_vld_r;
  logic [CntW-1:0]   empty_r;
  logic [SumW-1:0]   sum_r;
  logic [MmW-1:0]    mm_r;
  logic [HashW-1:0]  est_r;

  // Result registers.
  logic              out_valid_r;
  logic [EstW-1:0]   out_est_r;
  logic [EmptyW-1:0] out_empty_r;
  logic [SumW-1:0]   out_sum_r;
  logic              out_sat_r;

  logic              accept;
  logic [CntW-1:0]   m_sel;
  logic [CwW-1:0]    w_sel;
  logic [CtrW-1:0]   mask_sel;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [CtrW-1:0]   mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  logic [CtrW-1:0]   mem_rdata;

  logic [CtrW-1:0]   cur_cnt;
  logic [CtrW-1:0]   rank_sat;
  logic [RankW-1:0]  rank;
  logic [SumW-1:0]   term;
  logic [ProdW-1:0]  prod;
  logic              round_up;

  hll_pkg::div_req_t div_req;
  hll_pkg::div_rsp_t div_rsp;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Buckets in use: zero counts as one, above the table size it is clamped.
  always_comb begin
    if (bucket_count_r == '0) begin
      m_sel = CntW'(1);
    end else if (32'(bucket_count_r) > MAX_BUCKETS) begin
      m_sel = CntW'(MAX_BUCKETS);
    end else begin
      m_sel = CntW'(bucket_count_r);
    end
  end

  // Counter mask from the configured width, clamped to one through eight bits.
  always_comb begin
    if (counter_width_r == '0) begin
      w_sel = CwW'(1);
    end else if (counter_width_r > CwW'(CtrW)) begin
      w_sel = CwW'(CtrW);
    end else begin
      w_sel = counter_width_r;
    end
    mask_sel = CtrW'((16'd1 << w_sel) - 16'd1);
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r  <= hll_pkg::BUCKET_COUNT_RST;
      counter_width_r <= hll_pkg::COUNTER_WIDTH_RST;
      alpha_r         <= hll_pkg::ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hll_pkg::CFG_BUCKET_COUNT:  bucket_count_r  <= cfg_wdata[BcW-1:0];
        hll_pkg::CFG_COUNTER_WIDTH: counter_width_r <= cfg_wdata[CwW-1:0];
        hll_pkg::CFG_ALPHA:         alpha_r         <= cfg_wdata[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // Rank of the insert: trailing zeros of the upper half plus one, saturated.
  assign cur_cnt  = mem_rdata & mask_r;
  assign rank     = tz_r + RankW'(1);
  assign rank_sat = (CtrW'(rank) > mask_r) ? mask_r : CtrW'(rank);

  // Harmonic term 2^(32-c) for a counter of at most 32.
  assign term = SumW'(1) << (RankW'(Frac) - cur_cnt[RankW-1:0]);

  // Numerator alpha * m * m; the divider takes it shifted up by sixteen.
  assign prod     = ProdW'(alpha_r) * ProdW'(mm_r);
  assign round_up = {div_rsp.rem, 1'b0} >= {1'b0, sum_r};

  // Shared divider requests: hash modulo m, or numerator over the sum.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = in_hash;
    div_req.divisor  = SumW'(m_sel);
    if (state_r == S_IDLE) begin
      div_req.start = accept && (in_op == hll_pkg::OP_INSERT);
    end else if (state_r == S_EST_MUL2) begin
      div_req.start    = (sum_r != '0);
      div_req.dividend = {{PadW{1'b0}}, prod, {AlphaW{1'b0}}};
      div_req.divisor  = sum_r;
    end
  end

  hll_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Table port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bucket_r;
    mem_wdata = (cur_cnt > rank_sat) ? cur_cnt : rank_sat;
    mem_raddr = (state_r == S_EST_WALK) ? walk_idx_r : bucket_r;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_INS_WRITE) begin
      mem_we = 1'b1;
    end
  end

  hll_rank_mem #(
    .DEPTH  (MAX_BUCKETS),
    .ADDR_W (IdxW),
    .DATA_W (CtrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == IdxW'(MAX_BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == hll_pkg::OP_INSERT) ? S_INS_DIV : S_EST_WALK;
        end
      end
      S_INS_DIV: begin
        if (div_rsp.done) state_nxt = S_INS_READ;
      end
      S_INS_READ:  state_nxt = S_INS_WRITE;
      S_INS_WRITE: state_nxt = S_IDLE;
      S_EST_WALK: begin
        if ({1'b0, walk_idx_r} == m_r - CntW'(1)) state_nxt = S_EST_LAST;
      end
      S_EST_LAST: state_nxt = S_EST_MUL1;
      S_EST_MUL1: state_nxt = S_EST_MUL2;
      S_EST_MUL2: state_nxt = (sum_r == '0) ? S_EST_OUT : S_EST_DIV;
      S_EST_DIV: begin
        if (div_rsp.done) state_nxt = S_EST_OUT;
      end
      S_EST_OUT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_vld_r   <= (state_r == S_EST_WALK);
      out_valid_r <= (state_r == S_EST_OUT);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IdxW'(1);
      end
    end
  end

  // Working registers of inserts and estimates.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_r        <= m_sel;
      mask_r     <= mask_sel;
      hi_r       <= in_hash[HashW-1:HalfW];
      tz_r       <= '0;
      tz_found_r <= 1'b0;
      walk_idx_r <= '0;
      empty_r    <= '0;
      sum_r      <= '0;
    end else begin
      // Trailing zero count, one bit a cycle while the divider runs.
      if (state_r == S_INS_DIV) begin
        hi_r <= hi_r >> 1;
        if (!tz_found_r) begin
          if (hi_r[0]) begin
            tz_found_r <= 1'b1;
          end else if (tz_r != RankW'(Frac)) begin
            tz_r <= tz_r + RankW'(1);
          end
        end
        if (div_rsp.done) begin
          bucket_r <= div_rsp.rem[IdxW-1:0];
        end
      end
      if (state_r == S_EST_WALK) begin
        walk_idx_r <= walk_idx_r + IdxW'(1);
      end
      // Accumulate the entry read in the previous cycle.
      if (acc_vld_r) begin
        if (cur_cnt == '0) begin
          empty_r <= empty_r + CntW'(1);
        end else if (cur_cnt <= CtrW'(Frac)) begin
          sum_r <= sum_r + term;
        end
      end
      if (state_r == S_EST_MUL1) begin
        mm_r <= MmW'(m_r) * MmW'(m_r);
      end
      if (state_r == S_EST_MUL2 && sum_r == '0) begin
        est_r <= '1;
      end
      if (state_r == S_EST_DIV && div_rsp.done) begin
        est_r <= div_rsp.quot + HashW'(round_up);
      end
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_EST_OUT) begin
      out_sat_r   <= (est_r[HashW-1:EstW] != '0);
      out_est_r   <= (est_r[HashW-1:EstW] != '0) ? hll_pkg::EST_MAX : est_r[EstW-1:0];
      out_empty_r <= EmptyW'(empty_r);
      out_sum_r   <= sum_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_estimate  = out_est_r;
  assign out_empty_buckets = out_empty_r;
  assign out_harmonic_sum  = out_sum_r;
  assign out_saturated     = out_sat_r;

  // The result strobe never comes back to back, and the block is idle under it.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held two cycles");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE)) else $error("result strobe while busy");

  // The divider only finishes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_INS_DIV || state_r == S_EST_DIV))
    else $error("divider finished outside a divide step");

  // The table is never written during an estimate walk.
  a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EST_WALK || state_r == S_EST_LAST) |-> !mem_we)
    else $error("table written during estimate walk");

  // Empty buckets cannot outnumber the buckets walked.
  a_empty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EST_OUT) |-> (empty_r <= m_r))
    else $error("empty count exceeds bucket count");

endmodule

`default_nettype wire

/* rtl/hll_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on hll_pkg for the request and response words.
`default_nettype none

module hll_divider (
  input  wire               clk,
  input  wire               rst_n,
  input  hll_pkg::div_req_t req,
  output hll_pkg::div_rsp_t rsp
);

  localparam int DivW  = hll_pkg::HASH_W;
  localparam int RemW  = hll_pkg::SUM_W;
  localparam int CntW  = $clog2(DivW);

  logic [DivW-1:0] quot_r;
  logic [RemW-1:0] rem_r;
  logic [RemW-1:0] dvsr_r;
  logic [CntW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;

  logic [RemW:0]   trial;
  logic            fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem_r, quot_r[DivW-1]};
  assign fits  = trial >= {1'b0, dvsr_r};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(DivW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register turns into the quotient bit by bit.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvsr_r <= req.divisor;
    end else if (run_r) begin
      quot_r <= {quot_r[DivW-2:0], fits};
      rem_r  <= fits ? RemW'(trial - {1'b0, dvsr_r}) : trial[RemW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

/* rtl/hll_rank_mem.sv */
// Rank counter table: one write port and one registered read port.
// Standalone; sized by the top level.
`default_nettype none

module hll_rank_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  wire               clk,
  input  wire               we,
  input  wire  [ADDR_W-1:0] waddr,
  input  wire  [DATA_W-1:0] wdata,
  input  wire  [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* test/tb_hyperloglog_cardinality_sketch_top.sv */
`timescale 1ns / 1ps
// Testbench for hyperloglog_cardinality_sketch_top: directed and random command words
// checked against a built-in rank table predictor. Depends on hll_pkg and the top level.

module tb_hyperloglog_cardinality_sketch_top;

  localparam int TBL_DEPTH     = 1024;
  localparam int WORDS_TOTAL   = 1950;
  localparam int QUIET_WORDS   = 150;
  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES   = 1200;
  localparam int BC_BITS       = hll_pkg::BC_W;
  localparam int ALPHA_BITS    = hll_pkg::ALPHA_W;
  localparam int DATA_BITS     = hll_pkg::CFG_DATA_W;
  localparam logic [hll_pkg::SUM_W-1:0] SUM_CAP = {hll_pkg::SUM_W{1'b1}};

  typedef struct packed {
    logic [hll_pkg::EST_W-1:0]   raw;
    logic [hll_pkg::EMPTY_W-1:0] empties;
    logic [hll_pkg::SUM_W-1:0]   hsum;
    logic                        sat;
  } estimate_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_op;
  logic [hll_pkg::HASH_W-1:0]     in_hash;
  logic                           out_valid;
  logic [hll_pkg::EST_W-1:0]      out_raw_estimate;
  logic [hll_pkg::EMPTY_W-1:0]    out_empty_buckets;
  logic [hll_pkg::SUM_W-1:0]      out_harmonic_sum;
  logic                           out_saturated;
  logic                           cfg_we;
  logic [hll_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hll_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Predicted sketch: rank table and register copies.
  logic [hll_pkg::CTR_W-1:0]   rank_tbl [TBL_DEPTH];
  logic [hll_pkg::BC_W-1:0]    bucket_count_r;
  logic [hll_pkg::CW_W-1:0]    counter_width_r;
  logic [hll_pkg::ALPHA_W-1:0] alpha_r;

  estimate_t   estimates_due[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned tail_wait;
  bit          quiet_tail;

  hyperloglog_cardinality_sketch_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_hash           (in_hash),
    .out_valid         (out_valid),
    .out_raw_estimate  (out_raw_estimate),
    .out_empty_buckets (out_empty_buckets),
    .out_harmonic_sum  (out_harmonic_sum),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, sized for every word being a full-table estimate with the longest gaps.
  initial begin
    #30_000_000;
    $display("[hyperloglog_cardinality_sketch_top] ERROR");
    $finish;
  end

  // Bucket count in use: zero means one, anything above the table is clamped.
  function automatic int unsigned buckets_in_use();
    int unsigned m;
    m = bucket_count_r;
    if (m == 0) m = 1;
    if (m > TBL_DEPTH) m = TBL_DEPTH;
    return m;
  endfunction

  // Counter mask: width zero reads as one bit, widths above eight as eight.
  function automatic int unsigned counter_mask();
    int unsigned w;
    w = counter_width_r;
    if (w == 0) w = 1;
    if (w > hll_pkg::CTR_W) w = hll_pkg::CTR_W;
    return (1 << w) - 1;
  endfunction

  // Trailing zeros of the upper hash half plus one; an all-zero half gives 33.
  function automatic int unsigned hash_rank(logic [hll_pkg::HALF_W-1:0] upper);
    int unsigned n;
    n = 0;
    if (upper == '0) return hll_pkg::FRAC_BITS + 1;
    while (upper[n] == 1'b0) n++;
    return n + 1;
  endfunction

  function automatic void insert_into_sketch(logic [hll_pkg::HASH_W-1:0] hash);
    int unsigned m, b, rank, held, cap;
    m    = buckets_in_use();
    b    = 32'(hash % 64'(m));
    cap  = counter_mask();
    rank = hash_rank(hash[hll_pkg::HASH_W-1:hll_pkg::HALF_W]);
    held = rank_tbl[b] & cap;
    if (rank > cap) rank = cap;
    rank_tbl[b] = (held > rank) ? held[hll_pkg::CTR_W-1:0] : rank[hll_pkg::CTR_W-1:0];
  endfunction

  // Walk the buckets in use and form the raw estimate with round-half-up.
  function automatic estimate_t estimate_from_sketch();
    estimate_t   e;
    logic [63:0] hsum, num, quo;
    int unsigned m, cap, c, empties;
    m       = buckets_in_use();
    cap     = counter_mask();
    hsum    = '0;
    empties = 0;
    for (int i = 0; i < m; i++) begin
      c = rank_tbl[i] & cap;
      if (c == 0) empties++;
      else if (c <= hll_pkg::FRAC_BITS) hsum += 64'd1 << (hll_pkg::FRAC_BITS - c);
    end
    e.sat = 1'b0;
    if (hsum == '0) begin
      e.raw = hll_pkg::EST_MAX;
      e.sat = 1'b1;
    end else begin
      num = (64'(alpha_r) * 64'(m) * 64'(m)) << 16;
      quo = num / hsum;
      if (num % hsum >= hsum - hsum / 2) quo++;
      if (quo > 64'(hll_pkg::EST_MAX)) begin
        quo   = 64'(hll_pkg::EST_MAX);
        e.sat = 1'b1;
      end
      e.raw = quo[hll_pkg::EST_W-1:0];
    end
    e.empties = empties[hll_pkg::EMPTY_W-1:0];
    e.hsum    = (hsum > 64'(SUM_CAP)) ? SUM_CAP : hsum[hll_pkg::SUM_W-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Each result word is compared with the oldest pending estimate.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (estimates_due.size() == 0) begin
        report_mismatch("result word with no estimate pending", 64'(out_raw_estimate), '0);
      end else begin
        if (out_raw_estimate !== estimates_due[0].raw)
          report_mismatch("raw_estimate", 64'(out_raw_estimate),
                          64'(estimates_due[0].raw));
        if (out_empty_buckets !== estimates_due[0].empties)
          report_mismatch("empty_buckets", 64'(out_empty_buckets),
                          64'(estimates_due[0].empties));
        if (out_harmonic_sum !== estimates_due[0].hsum)
          report_mismatch("harmonic_sum", 64'(out_harmonic_sum),
                          64'(estimates_due[0].hsum));
        if (out_saturated !== estimates_due[0].sat)
          report_mismatch("saturated", 64'(out_saturated), 64'(estimates_due[0].sat));
        void'(estimates_due.pop_front());
      end
    end
  end

  task automatic write_reg(logic [hll_pkg::CFG_IDX_W-1:0] idx,
                           logic [hll_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      hll_pkg::CFG_BUCKET_COUNT:  bucket_count_r  = value[hll_pkg::BC_W-1:0];
      hll_pkg::CFG_COUNTER_WIDTH: counter_width_r = value[hll_pkg::CW_W-1:0];
      hll_pkg::CFG_ALPHA:         alpha_r         = value[hll_pkg::ALPHA_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = DATA_BITS'($urandom);
  endtask

  // Present one command word and hold it until the block takes it.
  task automatic send_word(logic op, logic [hll_pkg::HASH_W-1:0] hash);
    @(negedge clk);
    start   = 1'b1;
    in_op   = op;
    in_hash = hash;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == hll_pkg::OP_ESTIMATE) estimates_due.push_back(estimate_from_sketch());
    else insert_into_sketch(hash);
    words_sent++;
    @(negedge clk);
    start   = 1'b0;
    in_op   = 1'($urandom);
    in_hash = {$urandom, $urandom};
  endtask

  task automatic wait_ready();
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    while (estimates_due.size() != 0) @(posedge clk);
  endtask

  // Quiet point for register writes: no result pending, the last insert retired.
  task automatic settle();
    drain();
    wait_ready();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic idle_gap();
    if (quiet_tail) return;
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) == 0) wait_ready();
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Upper half with a random number of trailing zeros, all zero now and then.
  function automatic logic [hll_pkg::HASH_W-1:0] random_hash();
    logic [hll_pkg::HALF_W-1:0] upper;
    upper = $urandom << $urandom_range(0, 32);
    return {upper, 32'($urandom)};
  endfunction

  // With the default register set the bucket is the low ten hash bits.
  task automatic test_empty_table();
    send_word(hll_pkg::OP_ESTIMATE, '0);
  endtask

  task automatic test_rank_extremes();
    send_word(hll_pkg::OP_INSERT, {32'h8000_0000, 32'd5});
    send_word(hll_pkg::OP_ESTIMATE, '0);
    send_word(hll_pkg::OP_INSERT, {32'h0000_0000, 32'd7});
    send_word(hll_pkg::OP_INSERT, {hll_pkg::HASH_W{1'b1}});
    send_word(hll_pkg::OP_INSERT, '0);
    send_word(hll_pkg::OP_ESTIMATE, {hll_pkg::HASH_W{1'b1}});
  endtask

  // Stored ranks are read through the current width, so narrowing hides high bits.
  task automatic test_counter_width();
    settle();
    write_reg(hll_pkg::CFG_COUNTER_WIDTH, 16'd1);
    send_word(hll_pkg::OP_INSERT, {32'h0000_0100, 32'd9});
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_COUNTER_WIDTH, 16'd0);
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_COUNTER_WIDTH, 16'hFFFF);
    send_word(hll_pkg::OP_INSERT, {32'h0000_4000, 32'd11});
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_COUNTER_WIDTH, 16'd8);
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_COUNTER_WIDTH, 16'd6);
  endtask

  task automatic test_bucket_count();
    settle();
    write_reg(hll_pkg::CFG_BUCKET_COUNT, 16'd0);
    send_word(hll_pkg::OP_INSERT, random_hash());
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_BUCKET_COUNT, 16'h07FF);
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_BUCKET_COUNT, 16'd1);
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_BUCKET_COUNT, 16'd3);
    send_word(hll_pkg::OP_INSERT, {32'h0000_0002, 32'd4});
    send_word(hll_pkg::OP_INSERT, {32'h0000_0001, 32'd2});
    send_word(hll_pkg::OP_ESTIMATE, '0);
  endtask

  task automatic test_alpha();
    settle();
    write_reg(hll_pkg::CFG_ALPHA, 16'd0);
    send_word(hll_pkg::OP_ESTIMATE, '0);
    settle();
    write_reg(hll_pkg::CFG_ALPHA, 16'hFFFF);
    send_word(hll_pkg::OP_ESTIMATE, '0);
  endtask

  // Phases of random inserts and estimates, each under a fresh register set.
  task automatic test_random_traffic();
    int unsigned                 phase_len;
    logic [hll_pkg::BC_W-1:0]    bc;
    logic [hll_pkg::ALPHA_W-1:0] al;
    while (words_sent < WORDS_TOTAL) begin
      settle();
      case ($urandom_range(0, 9))
        0:       bc = '0;
        1:       bc = BC_BITS'($urandom_range(TBL_DEPTH + 1, 2047));
        2:       bc = BC_BITS'(TBL_DEPTH);
        3:       bc = BC_BITS'($urandom_range(65, TBL_DEPTH - 1));
        default: bc = BC_BITS'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       al = '0;
        1:       al = '1;
        default: al = ALPHA_BITS'($urandom);
      endcase
      write_reg(hll_pkg::CFG_BUCKET_COUNT, {5'($urandom), bc});
      write_reg(hll_pkg::CFG_COUNTER_WIDTH, {12'($urandom), 4'($urandom_range(0, 15))});
      write_reg(hll_pkg::CFG_ALPHA, al);
      phase_len = $urandom_range(30, 150);
      for (int k = 0; k < phase_len; k++) begin
        if (words_sent >= WORDS_TOTAL) break;
        quiet_tail = (words_sent + QUIET_WORDS >= WORDS_TOTAL);
        idle_gap();
        if ($urandom_range(0, 7) == 0) begin
          send_word(hll_pkg::OP_ESTIMATE, {$urandom, $urandom});
          // Now and then hold off until the estimate has come back.
          if ($urandom_range(0, 9) == 0) drain();
        end else begin
          send_word(hll_pkg::OP_INSERT, random_hash());
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_op      = hll_pkg::OP_INSERT;
    in_hash    = '0;
    cfg_we     = 1'b0;
    cfg_index  = hll_pkg::CFG_BUCKET_COUNT;
    cfg_wdata  = '0;
    mismatches = 0;
    words_sent = 0;
    quiet_tail = 1'b0;
    bucket_count_r  = hll_pkg::BUCKET_COUNT_RST;
    counter_width_r = hll_pkg::COUNTER_WIDTH_RST;
    alpha_r         = hll_pkg::ALPHA_RST;
    for (int i = 0; i < TBL_DEPTH; i++) rank_tbl[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_rank_extremes();
    test_counter_width();
    test_bucket_count();
    test_alpha();
    test_random_traffic();

    // Let outstanding estimates finish, then watch for stray result words.
    tail_wait = 0;
    while (estimates_due.size() != 0 && tail_wait < 20000) begin
      @(posedge clk);
      tail_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (estimates_due.size() != 0)
      report_mismatch("estimates never answered", 64'(estimates_due.size()), '0);
    if (mismatches == 0) begin
      $display("[hyperloglog_cardinality_sketch_top] OK");
    end else begin
      $display("[hyperloglog_cardinality_sketch_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hll_pkg.sv
rtl/hll_divider.sv
rtl/hll_rank_mem.sv
rtl/hyperloglog_cardinality_sketch_top.sv
test/tb_hyperloglog_cardinality_sketch_top.sv
